FILE: rtl/core/ascon_aead_core_assert.svh
// ----------------------------------------------------------------------------
// Ascon AEAD core assertion macros
// Shared concurrent assertion forms for the duplex core. They sample on
// clk and are disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASCON_AEAD_CORE_ASSERT_SVH
`define ASCON_AEAD_CORE_ASSERT_SVH

// Same-cycle implication.
`define ASCON_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASCON_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/ascon_pkg.sv
// ----------------------------------------------------------------------------
// Ascon package
// State type, request codes, register indexes and round helpers.
// ----------------------------------------------------------------------------
package ascon_pkg;

	localparam int NUM_WORDS = 5;

	typedef logic [63:0] word_t;
	typedef word_t [NUM_WORDS-1:0] state_t;

	typedef enum logic [2:0] {
		REQ_LOAD   = 3'd0,
		REQ_INIT   = 3'd1,
		REQ_ABSORB = 3'd2,
		REQ_ENC    = 3'd3,
		REQ_DEC    = 3'd4,
		REQ_FINAL  = 3'd5,
		REQ_DOMAIN = 3'd6
	} req_t;

	localparam logic REG_KEY_HIGH = 1'b0;
	localparam logic REG_KEY_LOW  = 1'b1;

	// Round index where a run starts: 12 rounds start at 0, 6 rounds at 6.
	localparam logic [3:0] RC_START_12 = 4'd0;
	localparam logic [3:0] RC_START_6  = 4'd6;
	localparam logic [3:0] RC_LAST     = 4'd11;

	// Round constant table 0xf0, 0xe1, ... 0x4b: high nibble counts down.
	function automatic logic [7:0] round_const(input logic [3:0] idx);
		round_const = {4'hf - idx, idx};
	endfunction

	function automatic word_t rotr(input word_t x, input int unsigned r);
		rotr = (x >> r) | (x << (64 - r));
	endfunction

endpackage

FILE: rtl/core/ascon_round.sv
// ----------------------------------------------------------------------------
// Ascon round
// One permutation round: constant addition, s-box layer, linear layer.
// ----------------------------------------------------------------------------
module ascon_round import ascon_pkg::*; (
	input  state_t     state_in,
	input  logic [7:0] rc,
	output state_t     state_out
);

	word_t x0, x1, x2, x3, x4;
	word_t t0, t1, t2, t3, t4;
	word_t y0, y1, y2, y3, y4;

	always_comb begin
		x0 = state_in[0] ^ state_in[4];
		x4 = state_in[4] ^ state_in[3];
		x2 = state_in[2] ^ {56'd0, rc} ^ state_in[1];
		x1 = state_in[1];
		x3 = state_in[3];

		t0 = ~x0 & x1;
		t1 = ~x1 & x2;
		t2 = ~x2 & x3;
		t3 = ~x3 & x4;
		t4 = ~x4 & x0;

		y0 = x0 ^ t1;
		y1 = x1 ^ t2;
		y2 = x2 ^ t3;
		y3 = x3 ^ t4;
		y4 = x4 ^ t0;
		y1 = y1 ^ y0;
		y0 = y0 ^ y4;
		y3 = y3 ^ y2;
		y2 = ~y2;

		state_out[0] = y0 ^ rotr(y0, 19) ^ rotr(y0, 28);
		state_out[1] = y1 ^ rotr(y1, 61) ^ rotr(y1, 39);
		state_out[2] = y2 ^ rotr(y2, 1) ^ rotr(y2, 6);
		state_out[3] = y3 ^ rotr(y3, 10) ^ rotr(y3, 17);
		state_out[4] = y4 ^ rotr(y4, 7) ^ rotr(y4, 41);
	end

endmodule

FILE: rtl/core/ascon_aead_core.sv
// ----------------------------------------------------------------------------
// Ascon AEAD core
// Ascon-128 style duplex engine on a 320-bit state with one shared round unit.
// ----------------------------------------------------------------------------
// Sequence: a request is accepted in ST_IDLE; init and finalize then run the full
// round schedule and absorb and non-first blocks its later part in ST_ROUND before
// ST_POST, while load, domain separation and first blocks go straight to ST_POST.
// One request at a time on the shared round unit: a new one is accepted only in
// ST_IDLE, and a held result stalls the post step.
// Reset clears the state words, keys and handshake control.
`include "ascon_aead_core_assert.svh"

module ascon_aead_core import ascon_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [63:0] cfg_wdata,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [2:0]  word_index,
	input  logic [63:0] data_in,
	input  logic        first_block,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] data_out,
	output logic [63:0] tag_high,
	output logic [63:0] tag_low
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_ROUND = 3'b010,
		ST_POST  = 3'b100
	} fsm_t;

	fsm_t        st_q;
	req_t        req_q;
	word_t       data_q;
	logic [3:0]  rc_idx_q;
	word_t       key_high_q;
	word_t       key_low_q;
	state_t      state_q;

	state_t      round_out;
	state_t      post_state;
	word_t       post_dout;
	logic        in_fire;
	logic        post_fire;
	req_t        req_in;

	assign in_ready  = (st_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	// Finish a request only when the output register is free or being drained.
	assign post_fire = (st_q == ST_POST) && (!out_valid || out_ready);
	assign req_in    = req_t'(req_type);

	// Shared round unit, driven by the state register every round cycle.
	ascon_round u_round (
		.state_in  (state_q),
		.rc        (round_const(rc_idx_q)),
		.state_out (round_out)
	);

	// Key registers: the user must write them only while idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_wr_en) begin
			if (cfg_index == REG_KEY_HIGH) begin
				key_high_q <= cfg_wdata;
			end else begin
				key_low_q <= cfg_wdata;
			end
		end
	end

	// Post step: key xor into words 3 and 4 after init and finalize, or the block xor on word 0, else no change.
	always_comb begin
		post_state = state_q;
		post_dout  = '0;
		case (req_q) inside
			REQ_INIT, REQ_FINAL: begin
				post_state[3] = state_q[3] ^ key_high_q;
				post_state[4] = state_q[4] ^ key_low_q;
			end
			REQ_ENC: begin
				post_dout     = data_q ^ state_q[0];
				post_state[0] = post_dout;
			end
			REQ_DEC: begin
				post_dout     = data_q ^ state_q[0];
				post_state[0] = data_q;
			end
			default: begin
				post_state = state_q;
			end
		endcase
	end

	// Sequencer and state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			req_q    <= REQ_LOAD;
			rc_idx_q <= '0;
			state_q  <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (in_fire) begin
						req_q <= req_in;
						st_q  <= ST_POST;
						unique case (req_in) inside
							REQ_LOAD: begin
								if (word_index < 3'(NUM_WORDS)) begin
									state_q[word_index] <= data_in;
								end
							end
							REQ_INIT: begin
								rc_idx_q <= RC_START_12;
								st_q     <= ST_ROUND;
							end
							REQ_ABSORB: begin
								state_q[0] <= state_q[0] ^ data_in;
								rc_idx_q   <= RC_START_6;
								st_q       <= ST_ROUND;
							end
							REQ_ENC, REQ_DEC: begin
								// Skip the permutation on the first block of a call.
								if (!first_block) begin
									rc_idx_q <= RC_START_6;
									st_q     <= ST_ROUND;
								end
							end
							REQ_FINAL: begin
								state_q[1] <= state_q[1] ^ key_high_q;
								state_q[2] <= state_q[2] ^ key_low_q;
								rc_idx_q   <= RC_START_12;
								st_q       <= ST_ROUND;
							end
							REQ_DOMAIN: begin
								state_q[4] <= state_q[4] ^ 64'd1;
							end
							default: begin
								req_q <= req_in;
							end
						endcase
					end
				end
				ST_ROUND: begin
					// Advance one round per cycle until the last constant.
					state_q  <= round_out;
					rc_idx_q <= rc_idx_q + 4'd1;
					if (rc_idx_q == RC_LAST) begin
						st_q <= ST_POST;
					end
				end
				ST_POST: begin
					if (post_fire) begin
						state_q <= post_state;
						st_q    <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Capture request payload; hold it for the post step.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_q <= data_in;
		end
	end

	// Output register: hold until taken, refill on a finished request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (post_fire) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (post_fire) begin
			data_out <= post_dout;
			tag_high <= post_state[3];
			tag_low  <= post_state[4];
		end
	end

	`ASCON_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready,
		"core still ready the cycle after accepting a request")
	`ASCON_ASSERT_NOW(a_round_idx_range, st_q == ST_ROUND, rc_idx_q <= RC_LAST,
		"round index past the last constant")
	`ASCON_ASSERT_NEXT(a_post_sets_valid, post_fire, out_valid && in_ready,
		"finished request did not present a result")

endmodule

FILE: tb/ascon_aead_core_tb.sv
// ----------------------------------------------------------------------------
// Ascon AEAD core testbench
// Drives load, init, absorb, domain, block and finalize requests through the
// valid/ready ports with random pacing on both sides. A shadow copy of the
// 320-bit state and the key registers predicts every result, and each
// returned result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ascon_aead_core_tb;
	import ascon_pkg::*;

	// Code 7 has no meaning in the request set and must leave the state alone.
	localparam logic [2:0] REQ_NONE = 3'd7;

	localparam int STALL_LIMIT     = 2000;  // cycles with no handshake at all
	localparam int TARGET_REQUESTS = 1600;
	localparam int SETTLE_CYCLES   = 20;    // above the worst-case request latency

	typedef struct packed {
		word_t data;
		word_t tag_hi;
		word_t tag_lo;
	} cipher_out_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic        cfg_index;
	logic [63:0] cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  req_type;
	logic [2:0]  word_index;
	logic [63:0] data_in;
	logic        first_block;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] data_out;
	logic [63:0] tag_high;
	logic [63:0] tag_low;

	// Shadow of the core: five state words and both key registers.
	word_t       model_word [NUM_WORDS];
	word_t       model_key_hi;
	word_t       model_key_lo;

	// Predicted results, oldest first.
	cipher_out_t expected_blocks [$];

	int          mismatches;
	int          requests_sent;
	int          quiet_cycles;
	int          ready_hold;
	bit          no_gaps;

	ascon_aead_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.word_index (word_index),
		.data_in    (data_in),
		.first_block(first_block),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.data_out   (data_out),
		.tag_high   (tag_high),
		.tag_low    (tag_low)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Shadow permutation
	// ------------------------------------------------------------------------

	function automatic word_t ror64(input word_t x, input int unsigned n);
		return (x >> n) | (x << (64 - n));
	endfunction

	// Apply the last n rounds of the twelve-round schedule to the shadow state.
	task automatic run_rounds(input int n);
		word_t x0, x1, x2, x3, x4;
		word_t t0, t1, t2, t3, t4;
		x0 = model_word[0];
		x1 = model_word[1];
		x2 = model_word[2];
		x3 = model_word[3];
		x4 = model_word[4];
		for (int r = 12 - n; r < 12; r++) begin
			// Round constants step down by 0x0f from 0xf0.
			x2 ^= 64'(240 - 15 * r);
			// Substitution layer, bit-sliced over the five words.
			x0 ^= x4;
			x4 ^= x3;
			x2 ^= x1;
			t0 = ~x0 & x1;
			t1 = ~x1 & x2;
			t2 = ~x2 & x3;
			t3 = ~x3 & x4;
			t4 = ~x4 & x0;
			x0 ^= t1;
			x1 ^= t2;
			x2 ^= t3;
			x3 ^= t4;
			x4 ^= t0;
			x1 ^= x0;
			x0 ^= x4;
			x3 ^= x2;
			x2 = ~x2;
			// Linear diffusion, one rotation pair per word.
			x0 ^= ror64(x0, 19) ^ ror64(x0, 28);
			x1 ^= ror64(x1, 61) ^ ror64(x1, 39);
			x2 ^= ror64(x2, 1) ^ ror64(x2, 6);
			x3 ^= ror64(x3, 10) ^ ror64(x3, 17);
			x4 ^= ror64(x4, 7) ^ ror64(x4, 41);
		end
		model_word[0] = x0;
		model_word[1] = x1;
		model_word[2] = x2;
		model_word[3] = x3;
		model_word[4] = x4;
	endtask

	// Advance the shadow by one request and return the result it must produce.
	task automatic predict_request(input logic [2:0] req, input logic [2:0] idx,
			input word_t data, input logic first, output cipher_out_t res);
		res.data = '0;
		case (req)
			REQ_LOAD: begin
				// Indexes past the last word are dropped.
				if (idx < NUM_WORDS)
					model_word[idx] = data;
			end
			REQ_INIT: begin
				run_rounds(12);
				model_word[3] ^= model_key_hi;
				model_word[4] ^= model_key_lo;
			end
			REQ_ABSORB: begin
				model_word[0] ^= data;
				run_rounds(6);
			end
			REQ_ENC: begin
				if (!first)
					run_rounds(6);
				res.data = data ^ model_word[0];
				model_word[0] = res.data;
			end
			REQ_DEC: begin
				if (!first)
					run_rounds(6);
				res.data = data ^ model_word[0];
				model_word[0] = data;
			end
			REQ_FINAL: begin
				model_word[1] ^= model_key_hi;
				model_word[2] ^= model_key_lo;
				run_rounds(12);
				model_word[3] ^= model_key_hi;
				model_word[4] ^= model_key_lo;
			end
			REQ_DOMAIN: begin
				model_word[4] ^= 64'd1;
			end
			default: begin
			end
		endcase
		res.tag_hi = model_word[3];
		res.tag_lo = model_word[4];
	endtask

	// ------------------------------------------------------------------------
	// Pacing and data helpers
	// ------------------------------------------------------------------------

	// Mostly back-to-back, sometimes a short gap, rarely a long hole.
	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Random word with the all-zero and all-one extremes mixed in.
	function automatic word_t rand_word();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	// ------------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------------

	// Present one request, hold it until accepted, then record its prediction.
	// Returns at the edge of acceptance with in_valid still high, so a
	// following request with no gap keeps valid asserted.
	task automatic send_request(input logic [2:0] req, input logic [2:0] idx,
			input word_t data, input logic first);
		int          gap;
		cipher_out_t res;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= req;
		word_index  <= idx;
		data_in     <= data;
		first_block <= first;
		do @(posedge clk); while (!in_ready);
		predict_request(req, idx, data, first, res);
		expected_blocks.push_back(res);
		requests_sent++;
	endtask

	// Drop valid and hold off until every predicted result has been returned.
	task automatic drain_requests();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_blocks.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	// Write both key registers; call only while the core is idle.
	task automatic set_keys(input word_t hi, input word_t lo);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_KEY_HIGH;
		cfg_wdata <= hi;
		@(posedge clk);
		cfg_index <= REG_KEY_LOW;
		cfg_wdata <= lo;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		model_key_hi = hi;
		model_key_lo = lo;
	endtask

	// One well-formed message: load, init, ad words, separation, blocks, tag.
	task automatic run_session();
		int n_ad;
		int n_blk;
		for (int w = 0; w < NUM_WORDS; w++)
			send_request(REQ_LOAD, 3'(w), rand_word(), 1'($urandom_range(0, 1)));
		send_request(REQ_INIT, 3'($urandom_range(0, 7)), rand_word(),
			1'($urandom_range(0, 1)));
		n_ad = $urandom_range(0, 3);
		for (int a = 0; a < n_ad; a++)
			send_request(REQ_ABSORB, 3'($urandom_range(0, 7)), rand_word(), 1'b0);
		send_request(REQ_DOMAIN, 3'($urandom_range(0, 7)), rand_word(),
			1'($urandom_range(0, 1)));
		n_blk = $urandom_range(1, 4);
		for (int b = 0; b < n_blk; b++)
			send_request($urandom_range(0, 1) ? REQ_ENC : REQ_DEC,
				3'($urandom_range(0, 7)), rand_word(), 1'(b == 0));
		send_request(REQ_FINAL, 3'($urandom_range(0, 7)), rand_word(),
			1'($urandom_range(0, 1)));
	endtask

	// Arbitrary requests in any order, including bad indexes and code 7.
	task automatic run_noise(input int count);
		for (int i = 0; i < count; i++)
			send_request(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
				rand_word(), 1'($urandom_range(0, 1)));
	endtask

	// ------------------------------------------------------------------------
	// Test tasks
	// ------------------------------------------------------------------------

	// Field extremes, every request code and each corner of the request set.
	task automatic test_directed_requests();
		set_keys('1, '1);
		send_request(REQ_LOAD, 3'd0, '0, 1'b0);
		send_request(REQ_LOAD, 3'd1, '1, 1'b1);
		send_request(REQ_LOAD, 3'd2, 64'h5555_5555_5555_5555, 1'b0);
		send_request(REQ_LOAD, 3'd3, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
		send_request(REQ_LOAD, 3'd4, 64'h0123_4567_89ab_cdef, 1'b1);
		// Out-of-range word indexes must change nothing.
		send_request(REQ_LOAD, 3'd5, '1, 1'b0);
		send_request(REQ_LOAD, 3'd7, '1, 1'b1);
		// first_block must be ignored outside the block requests.
		send_request(REQ_INIT, 3'd7, '1, 1'b1);
		send_request(REQ_ABSORB, 3'd0, '1, 1'b1);
		send_request(REQ_ABSORB, 3'd0, '0, 1'b0);
		send_request(REQ_DOMAIN, 3'd0, '1, 1'b1);
		send_request(REQ_ENC, 3'd0, '0, 1'b1);
		send_request(REQ_ENC, 3'd7, '1, 1'b0);
		send_request(REQ_DEC, 3'd0, 64'hfedc_ba98_7654_3210, 1'b0);
		send_request(REQ_DEC, 3'd0, '1, 1'b1);
		send_request(REQ_FINAL, 3'd0, '1, 1'b1);
		// Unknown code leaves state alone and returns zero data.
		send_request(REQ_NONE, 3'd7, '1, 1'b1);
		send_request(REQ_NONE, 3'd0, '0, 1'b0);
		drain_requests();
		set_keys('0, '0);
		send_request(REQ_INIT, 3'd0, '0, 1'b0);
		send_request(REQ_ENC, 3'd0, '1, 1'b0);
		send_request(REQ_FINAL, 3'd0, '0, 1'b0);
		drain_requests();
	endtask

	// Full messages under each extreme key pairing.
	task automatic test_key_extremes();
		word_t hi_set [4];
		word_t lo_set [4];
		hi_set = '{'0, '1, '0, '1};
		lo_set = '{'0, '0, '1, '1};
		for (int k = 0; k < 4; k++) begin
			drain_requests();
			set_keys(hi_set[k], lo_set[k]);
			run_session();
		end
		drain_requests();
	endtask

	// No idling on either side, then wait for the core to empty out.
	task automatic test_streaming();
		no_gaps = 1'b1;
		for (int s = 0; s < 4; s++)
			run_session();
		run_noise(10);
		no_gaps = 1'b0;
		drain_requests();
	endtask

	// Random messages and noise until the request budget is spent.
	task automatic test_random_traffic();
		int sessions;
		sessions = 0;
		while (requests_sent < TARGET_REQUESTS) begin
			// Rekey between messages now and then, only once idle.
			if (sessions % 10 == 9) begin
				drain_requests();
				set_keys(rand_word(), rand_word());
			end
			if ($urandom_range(0, 99) < 80)
				run_session();
			else
				run_noise($urandom_range(5, 15));
			// Occasional full stop so the sender waits out the pipeline.
			if ($urandom_range(0, 9) == 0)
				drain_requests();
			// Occasional stretch with no idling at all.
			no_gaps = ($urandom_range(0, 7) == 0);
			sessions++;
		end
		no_gaps = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Stimulus sequence
	// ------------------------------------------------------------------------

	initial begin
		// Hold every input at a known value from time zero.
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_index     = REG_KEY_HIGH;
		cfg_wdata     = '0;
		in_valid      = 1'b0;
		req_type      = REQ_LOAD;
		word_index    = '0;
		data_in       = '0;
		first_block   = 1'b0;
		out_ready     = 1'b0;
		mismatches    = 0;
		requests_sent = 0;
		quiet_cycles  = 0;
		ready_hold    = 0;
		no_gaps       = 1'b0;
		model_key_hi  = '0;
		model_key_lo  = '0;
		for (int w = 0; w < NUM_WORDS; w++)
			model_word[w] = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_requests();
		test_key_extremes();
		test_streaming();
		test_random_traffic();

		// Let the last results come out, then give the core time to settle.
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_blocks.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("ascon_aead_core_tb: clean");
		end else begin
			$display("ascon_aead_core_tb: errors");
		end
		$finish;
	end

	// ------------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------------

	// Hold out_ready low for a random stall after each ready cycle.
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			ready_hold = pick_gap();
		end
	end

	// Compare each accepted result against the oldest prediction.
	always @(posedge clk) begin : result_check
		cipher_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_blocks.size() == 0) begin
				$display("%0t: unexpected result data_out=%h tag_high=%h tag_low=%h",
					$time, data_out, tag_high, tag_low);
				mismatches++;
			end else begin
				want = expected_blocks.pop_front();
				if (data_out !== want.data) begin
					$display("%0t: data_out expected %h actual %h",
						$time, want.data, data_out);
					mismatches++;
				end
				if (tag_high !== want.tag_hi) begin
					$display("%0t: tag_high expected %h actual %h",
						$time, want.tag_hi, tag_high);
					mismatches++;
				end
				if (tag_low !== want.tag_lo) begin
					$display("%0t: tag_low expected %h actual %h",
						$time, want.tag_lo, tag_low);
					mismatches++;
				end
			end
		end
	end

	// Abort when neither channel has moved for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
				$display("ascon_aead_core_tb: errors");
				$finish;
			end
		end
	end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/ascon_pkg.sv
rtl/core/ascon_round.sv
rtl/core/ascon_aead_core.sv
tb/ascon_aead_core_tb.sv
